@@ rtl/ksf_pkg.sv @@
// ksf_pkg: shared constants and state encoding for the spanning forest core
// no dependencies
package ksf_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int DEF_COST_BITS    = 16;

    // width used for vertex range compares (holds values up to 255)
    localparam int CMP_BITS = 8;

    localparam logic [5:0] VCOUNT_RESET = 6'd32;

    typedef enum logic [4:0] {
        S_LOAD     = 5'b00001,
        S_FIND     = 5'b00010,
        S_CHAIN    = 5'b00100,
        S_OUT      = 5'b01000,
        S_OUT_LAST = 5'b10000
    } t_state;

endpackage

@@ rtl/kruskal_spanning_forest_core.sv @@
// Spanning forest core: loads matrix entries into an edge memory, then emits
// the minimum spanning forest edges in rising cost order.
// Entries are taken only while o_stall is low, in the load state; after the last
// entry every step of the scan makes one pass over the stored edges to pick
// the next edge by cost and load order, then a label lookup through the cell
// chain. One graph is worked at a time.
// Reset: synchronous, active low; clears control state, vertex_count to 32.
module kruskal_spanning_forest_core
    import ksf_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int COST_BITS    = DEF_COST_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [5:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_row_vertex,
    input  logic [4:0]  i_col_vertex,
    input  logic [15:0] i_weight,
    input  logic        i_last_entry,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_low_vertex,
    output logic [5:0]  o_high_vertex,
    output logic [15:0] o_edge_cost,
    output logic        o_last_edge
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AW  = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int DW  = 2 * VW + COST_BITS;
    localparam int KW  = COST_BITS + AW;
    localparam logic [31:0] COST_LIMIT = 32'((64'd1 << COST_BITS) - 64'd1);

    t_state r_state, n_state;

    logic [5:0]          r_vcount;
    logic [ECW-1:0]      r_ecount;
    logic [DW-1:0]       r_mem [MAX_EDGES];
    logic [DW-1:0]       r_rd_data;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_idx;
    logic [ECW-1:0]      r_iss;
    logic                r_best_vld, r_prev_vld;
    logic [KW-1:0]       r_best_key, r_prev_key;
    logic [VW-1:0]       r_best_a, r_best_b;
    logic [CMP_BITS-1:0] r_n;
    logic                r_pend_vld, r_fin;
    logic [VW-1:0]       r_pend_a, r_pend_b;
    logic [COST_BITS-1:0] r_pend_cost;
    logic                r_out_vld, r_out_last;
    logic [5:0]          r_out_lo, r_out_hi;
    logic [15:0]         r_out_cost;

    logic [CMP_BITS-1:0] w_cfg8, w_nv;
    logic                w_in_acc, w_out_acc, w_store;
    logic [31:0]         w_w32;
    logic [COST_BITS-1:0] w_cost;
    logic [ECW-1:0]      w_ecount_nx;
    logic [KW-1:0]       w_rd_key;
    logic                w_cand, w_pass_end, w_launch, w_join, w_is_final;
    logic [VW-1:0]       w_rd_a, w_rd_b;
    logic [COST_BITS-1:0] w_rd_cost;

    logic          w_tok_vld [MAX_VERTICES + 1];
    logic [VW-1:0] w_tok_a   [MAX_VERTICES + 1];
    logic [VW-1:0] w_tok_b   [MAX_VERTICES + 1];
    logic [VW-1:0] w_tok_la  [MAX_VERTICES + 1];
    logic [VW-1:0] w_tok_lb  [MAX_VERTICES + 1];
    logic          w_init;

    // effective vertex count
    always_comb begin
        w_cfg8 = CMP_BITS'(r_vcount);
        if (w_cfg8 == '0) begin
            w_nv = CMP_BITS'(1);
        end else if (w_cfg8 > CMP_BITS'(MAX_VERTICES)) begin
            w_nv = CMP_BITS'(MAX_VERTICES);
        end else begin
            w_nv = w_cfg8;
        end
    end

    assign o_stall   = (r_state != S_LOAD);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_vld && !i_stall;

    assign w_w32   = 32'(i_weight);
    assign w_cost  = COST_BITS'((w_w32 > COST_LIMIT) ? COST_LIMIT : w_w32);
    assign w_store = w_in_acc && (i_weight != '0)
                  && (CMP_BITS'(i_row_vertex) < w_nv)
                  && (CMP_BITS'(i_col_vertex) < w_nv)
                  && (r_ecount < ECW'(MAX_EDGES));
    assign w_ecount_nx = w_store ? r_ecount + ECW'(1) : r_ecount;

    // edge memory
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_ecount[AW-1:0]] <= {VW'(i_row_vertex), VW'(i_col_vertex), w_cost};
        end
        r_rd_data <= r_mem[r_iss[AW-1:0]];
        r_rd_idx  <= r_iss[AW-1:0];
    end

    assign {w_rd_a, w_rd_b, w_rd_cost} = r_rd_data;
    assign w_rd_key = {w_rd_cost, r_rd_idx};
    // next edge in (cost, load order) after the previous pick
    assign w_cand = r_rd_vld
                 && (!r_prev_vld || w_rd_key > r_prev_key)
                 && (!r_best_vld || w_rd_key < r_best_key);
    assign w_pass_end = (r_state == S_FIND) && (r_iss == r_ecount) && !r_rd_vld;
    assign w_launch   = w_pass_end && r_best_vld;

    assign w_join     = (r_state == S_CHAIN) && w_tok_vld[MAX_VERTICES]
                     && (w_tok_la[MAX_VERTICES] != w_tok_lb[MAX_VERTICES]);
    assign w_is_final = (r_n + CMP_BITS'(1)) == (w_nv - CMP_BITS'(1));
    assign w_init     = w_in_acc && i_last_entry;

    // label chain
    assign w_tok_vld[0] = w_launch;
    assign w_tok_a[0]   = r_best_a;
    assign w_tok_b[0]   = r_best_b;
    assign w_tok_la[0]  = '0;
    assign w_tok_lb[0]  = '0;

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        ksf_cell #(
            .VW  (VW),
            .IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (w_init),
            .i_rel_en   (w_join),
            .i_rel_from (w_tok_la[MAX_VERTICES]),
            .i_rel_to   (w_tok_lb[MAX_VERTICES]),
            .i_tok_vld  (w_tok_vld[g]),
            .i_tok_a    (w_tok_a[g]),
            .i_tok_b    (w_tok_b[g]),
            .i_tok_la   (w_tok_la[g]),
            .i_tok_lb   (w_tok_lb[g]),
            .o_tok_vld  (w_tok_vld[g+1]),
            .o_tok_a    (w_tok_a[g+1]),
            .o_tok_b    (w_tok_b[g+1]),
            .o_tok_la   (w_tok_la[g+1]),
            .o_tok_lb   (w_tok_lb[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_init) begin
                    n_state = (w_nv == CMP_BITS'(1)) ? S_LOAD : S_FIND;
                end
            end
            S_FIND: begin
                if (w_pass_end) begin
                    if (r_best_vld) begin
                        n_state = S_CHAIN;
                    end else if (r_pend_vld) begin
                        n_state = S_OUT_LAST;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_CHAIN: begin
                if (w_tok_vld[MAX_VERTICES]) begin
                    if (!w_join) begin
                        n_state = S_FIND;
                    end else if (r_pend_vld) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = w_is_final ? S_OUT_LAST : S_FIND;
                    end
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_state = r_fin ? S_OUT_LAST : S_FIND;
                end
            end
            S_OUT_LAST: begin
                if (w_out_acc) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_vcount   <= VCOUNT_RESET;
            r_ecount   <= '0;
            r_iss      <= '0;
            r_rd_vld   <= 1'b0;
            r_best_vld <= 1'b0;
            r_prev_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_fin      <= 1'b0;
            r_n        <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            r_rd_vld <= (r_state == S_FIND) && (r_iss != r_ecount);
            if (w_out_acc) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        r_ecount <= (i_last_entry && w_nv == CMP_BITS'(1)) ? '0 : w_ecount_nx;
                    end
                    r_iss      <= '0;
                    r_best_vld <= 1'b0;
                    r_prev_vld <= 1'b0;
                    r_pend_vld <= 1'b0;
                    r_fin      <= 1'b0;
                    r_n        <= '0;
                end
                S_FIND: begin
                    if (r_iss != r_ecount) begin
                        r_iss <= r_iss + ECW'(1);
                    end
                    if (w_cand) begin
                        r_best_vld <= 1'b1;
                        r_best_key <= w_rd_key;
                        r_best_a   <= w_rd_a;
                        r_best_b   <= w_rd_b;
                    end
                    if (w_pass_end) begin
                        if (r_best_vld) begin
                            r_prev_vld <= 1'b1;
                            r_prev_key <= r_best_key;
                        end else begin
                            if (r_pend_vld) begin
                                r_out_vld <= 1'b1;
                            end
                            r_ecount <= '0;
                        end
                    end
                    if (w_pass_end && !r_best_vld && r_pend_vld) begin
                        r_out_last <= 1'b1;
                        r_out_lo   <= 6'(r_pend_a) + 6'd1;
                        r_out_hi   <= 6'(r_pend_b) + 6'd1;
                        r_out_cost <= 16'(r_pend_cost);
                        r_pend_vld <= 1'b0;
                    end
                end
                S_CHAIN: begin
                    r_iss      <= '0;
                    r_best_vld <= 1'b0;
                    if (w_join) begin
                        r_n         <= r_n + CMP_BITS'(1);
                        r_pend_vld  <= 1'b1;
                        r_pend_a    <= (r_best_a <= r_best_b) ? r_best_a : r_best_b;
                        r_pend_b    <= (r_best_a <= r_best_b) ? r_best_b : r_best_a;
                        r_pend_cost <= r_best_key[KW-1 -: COST_BITS];
                        r_fin       <= w_is_final;
                        if (r_pend_vld) begin
                            r_out_vld  <= 1'b1;
                            r_out_last <= 1'b0;
                            r_out_lo   <= 6'(r_pend_a) + 6'd1;
                            r_out_hi   <= 6'(r_pend_b) + 6'd1;
                            r_out_cost <= 16'(r_pend_cost);
                        end else if (w_is_final) begin
                            r_out_vld  <= 1'b1;
                            r_out_last <= 1'b1;
                            r_out_lo   <= 6'((r_best_a <= r_best_b) ? r_best_a : r_best_b)
                                          + 6'd1;
                            r_out_hi   <= 6'((r_best_a <= r_best_b) ? r_best_b : r_best_a)
                                          + 6'd1;
                            r_out_cost <= 16'(r_best_key[KW-1 -: COST_BITS]);
                            r_pend_vld <= 1'b0;
                            r_ecount   <= '0;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_acc && r_fin) begin
                        r_out_vld  <= 1'b1;
                        r_out_last <= 1'b1;
                        r_out_lo   <= 6'(r_pend_a) + 6'd1;
                        r_out_hi   <= 6'(r_pend_b) + 6'd1;
                        r_out_cost <= 16'(r_pend_cost);
                        r_pend_vld <= 1'b0;
                        r_ecount   <= '0;
                    end
                end
                S_OUT_LAST: begin
                    r_ecount <= '0;
                end
                default: begin
                    r_ecount <= '0;
                end
            endcase
        end
    end

    assign o_valid       = r_out_vld;
    assign o_low_vertex  = r_out_lo;
    assign o_high_vertex = r_out_hi;
    assign o_edge_cost   = r_out_cost;
    assign o_last_edge   = r_out_last;

endmodule

@@ rtl/ksf_cell.sv @@
// ksf_cell: one vertex of the label chain, holds the component label of its vertex
// a lookup token passes through one cell per cycle; uses ksf_pkg
module ksf_cell
    import ksf_pkg::*;
#(
    parameter int VW  = 5,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_init,
    input  logic          i_rel_en,
    input  logic [VW-1:0] i_rel_from,
    input  logic [VW-1:0] i_rel_to,
    input  logic          i_tok_vld,
    input  logic [VW-1:0] i_tok_a,
    input  logic [VW-1:0] i_tok_b,
    input  logic [VW-1:0] i_tok_la,
    input  logic [VW-1:0] i_tok_lb,
    output logic          o_tok_vld,
    output logic [VW-1:0] o_tok_a,
    output logic [VW-1:0] o_tok_b,
    output logic [VW-1:0] o_tok_la,
    output logic [VW-1:0] o_tok_lb
);

    logic [VW-1:0] r_label;
    logic          r_tok_vld;
    logic [VW-1:0] r_tok_a, r_tok_b, r_tok_la, r_tok_lb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label   <= VW'(IDX);
            r_tok_vld <= 1'b0;
        end else begin
            if (i_init) begin
                r_label <= VW'(IDX);
            end else if (i_rel_en && r_label == i_rel_from) begin
                r_label <= i_rel_to;
            end
            r_tok_vld <= i_tok_vld;
        end
    end

    // endpoint whose index matches this cell picks up its label
    always_ff @(posedge i_clk) begin
        r_tok_a  <= i_tok_a;
        r_tok_b  <= i_tok_b;
        r_tok_la <= (i_tok_a == VW'(IDX)) ? r_label : i_tok_la;
        r_tok_lb <= (i_tok_b == VW'(IDX)) ? r_label : i_tok_lb;
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok_a   = r_tok_a;
    assign o_tok_b   = r_tok_b;
    assign o_tok_la  = r_tok_la;
    assign o_tok_lb  = r_tok_lb;

endmodule
